// ===== design/aavr_pkg.sv =====
// ----------------------------------------------------------------------------
// aavr_pkg - shared types and constants for the axis-angle rotator
// Word types, CORDIC arctangent table and fixed-point constants.
// ----------------------------------------------------------------------------
package aavr_pkg;

    localparam int ATAN_N = 24;

    localparam logic signed [32:0] LEN2_MIN = 33'sd263093591;
    localparam logic signed [32:0] LEN2_MAX = 33'sd273831008;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] QUARTER  = 34'sd1073741824;
    localparam logic signed [33:0] HALF     = 34'sd2147483648;
    localparam logic signed [34:0] ONE_Q30  = 35'sd1073741824;

    // aa index: xx, yy, zz, xy, xz, yz
    localparam int AXX = 0;
    localparam int AYY = 1;
    localparam int AZZ = 2;
    localparam int AXY = 3;
    localparam int AXZ = 4;
    localparam int AYZ = 5;

    typedef struct packed {
        logic [2:0][31:0] t;
        logic [2:0][15:0] a;
        logic [5:0][31:0] aa;
        logic             ok;
        logic             flip;
    } t_item;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_cordic;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] f_atan(input int i);
        logic [29:0] v;
        case (i)
            0:       v = 30'd536870912;
            1:       v = 30'd316933406;
            2:       v = 30'd167458907;
            3:       v = 30'd85004756;
            4:       v = 30'd42667331;
            5:       v = 30'd21354465;
            6:       v = 30'd10679838;
            7:       v = 30'd5340245;
            8:       v = 30'd2670163;
            9:       v = 30'd1335087;
            10:      v = 30'd667544;
            11:      v = 30'd333772;
            12:      v = 30'd166886;
            13:      v = 30'd83443;
            14:      v = 30'd41722;
            15:      v = 30'd20861;
            16:      v = 30'd10430;
            17:      v = 30'd5215;
            18:      v = 30'd2608;
            19:      v = 30'd1304;
            20:      v = 30'd652;
            21:      v = 30'd326;
            22:      v = 30'd163;
            23:      v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/aavr_if.sv =====
// ----------------------------------------------------------------------------
// aavr_in_if / aavr_out_if - valid/ready channels of the rotator
// Input word: target vector, axis, angle. Output word: rotated vector, ok.
// ----------------------------------------------------------------------------
interface aavr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] angle;

    modport source (output valid, target_x, target_y, target_z,
                    axis_x, axis_y, axis_z, angle, input ready);
    modport sink   (input valid, target_x, target_y, target_z,
                    axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aavr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               ok;

    modport source (output valid, result_x, result_y, result_z, ok, input ready);
    modport sink   (input valid, result_x, result_y, result_z, ok, output ready);
endinterface

// ===== design/aavr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aavr_cordic_cell - one CORDIC micro-rotation
// Rotates (x, y) by +-atan(2^-STAGE), carries the word alongside.
// ----------------------------------------------------------------------------
module aavr_cordic_cell
    import aavr_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_cordic i_st,
    input  t_item   i_item,
    output logic    o_vld,
    output t_cordic o_st,
    output t_item   o_item
);

    logic               r_vld;
    t_cordic            r_st;
    t_item              r_item;
    t_cordic            n_st;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;

    always_comb begin
        dx = i_st.y >>> STAGE;
        dy = i_st.x >>> STAGE;
        at = signed'({4'b0, f_atan(STAGE)});
        if (!i_st.z[33]) begin
            n_st.x = i_st.x - dx;
            n_st.y = i_st.y + dy;
            n_st.z = i_st.z - at;
        end else begin
            n_st.x = i_st.x + dx;
            n_st.y = i_st.y - dy;
            n_st.z = i_st.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st   <= n_st;
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_st   = r_st;
    assign o_item = r_item;

endmodule

// ===== design/axis_angle_vector_rotation_top.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_top - Rodrigues axis-angle vector rotator
//
//   channel | dir | word
//   --------+-----+----------------------------------------------
//   i_vec   | in  | target_x/y/z Q16.16, axis_x/y/z Q2.14, angle
//   o_rot   | out | result_x/y/z Q16.16 saturated, ok
//
// One word per cycle while o_rot takes its words; the registers, in order, are
// the axis check, one cell per CORDIC step, two matrix stages, product, and
// sum/round/saturate into the output register.
// The whole pipeline advances together: it holds while o_rot has a word
// waiting that is not taken, and i_vec.ready follows that enable.
// Reset (synchronous, active low) clears only the valid bits.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_top
    import aavr_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aavr_in_if.sink    i_vec,
    aavr_out_if.source o_rot
);

    // cells actually built; table holds 24 steps
    localparam int NCELL = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;

    logic en;

    // ---------------- front: axis check, angle fold ----------------
    logic               r_vld0;
    t_cordic            r_st0;
    t_item              r_item0;
    t_cordic            n_st0;
    t_item              n_item0;
    logic signed [31:0] za;
    logic signed [33:0] z34;
    logic signed [32:0] q;
    logic signed [31:0] sq [3];
    logic signed [15:0] ax, ay, az;

    always_comb begin
        ax = i_vec.axis_x;
        ay = i_vec.axis_y;
        az = i_vec.axis_z;
        sq[0] = 32'(ax) * 32'(ax);
        sq[1] = 32'(ay) * 32'(ay);
        sq[2] = 32'(az) * 32'(az);
        q = 33'(sq[0]) + 33'(sq[1]) + 33'(sq[2]);

        n_item0.t[0] = i_vec.target_x;
        n_item0.t[1] = i_vec.target_y;
        n_item0.t[2] = i_vec.target_z;
        n_item0.a[0] = ax;
        n_item0.a[1] = ay;
        n_item0.a[2] = az;
        n_item0.aa[AXX] = sq[0];
        n_item0.aa[AYY] = sq[1];
        n_item0.aa[AZZ] = sq[2];
        n_item0.aa[AXY] = 32'(ax) * 32'(ay);
        n_item0.aa[AXZ] = 32'(ax) * 32'(az);
        n_item0.aa[AYZ] = 32'(ay) * 32'(az);
        n_item0.ok = (q >= LEN2_MIN) && (q <= LEN2_MAX);

        // binary angle in [-1/2, 1/2) turn, folded into +-1/4
        za  = signed'({i_vec.angle, 16'h0000});
        z34 = 34'(za);
        n_item0.flip = 1'b0;
        if (z34 > QUARTER) begin
            z34 = z34 - HALF;
            n_item0.flip = 1'b1;
        end else if (z34 < -QUARTER) begin
            z34 = z34 + HALF;
            n_item0.flip = 1'b1;
        end
        n_st0.x = GAIN_Q30;
        n_st0.y = '0;
        n_st0.z = z34;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (en) begin
            r_vld0 <= i_vec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st0   <= n_st0;
            r_item0 <= n_item0;
        end
    end

    // ---------------- CORDIC chain ----------------
    logic    c_vld  [NCELL+1];
    t_cordic c_st   [NCELL+1];
    t_item   c_item [NCELL+1];

    assign c_vld[0]  = r_vld0;
    assign c_st[0]   = r_st0;
    assign c_item[0] = r_item0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        aavr_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (c_vld[g]),
            .i_st   (c_st[g]),
            .i_item (c_item[g]),
            .o_vld  (c_vld[g+1]),
            .o_st   (c_st[g+1]),
            .o_item (c_item[g+1])
        );
    end

    // ---------------- M1: oc*aa, s*a, c/4 ----------------
    logic               r_vld1;
    t_item              r_item1;
    logic signed [66:0] r_p [6];
    logic signed [49:0] r_sa [3];
    logic signed [33:0] r_rc;
    logic signed [33:0] cc, ss;
    logic signed [34:0] oc;

    always_comb begin
        cc = c_item[NCELL].flip ? -c_st[NCELL].x : c_st[NCELL].x;
        ss = c_item[NCELL].flip ? -c_st[NCELL].y : c_st[NCELL].y;
        oc = ONE_Q30 - 35'(cc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (en) begin
            r_vld1 <= c_vld[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item1 <= c_item[NCELL];
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= 67'(oc) * 67'($signed(c_item[NCELL].aa[k]));
            end
            for (int k = 0; k < 3; k++) begin
                r_sa[k] <= 50'(ss) * 50'($signed(c_item[NCELL].a[k]));
            end
            r_rc <= (cc + 34'sd2) >>> 2;
        end
    end

    // ---------------- M2: matrix entries, clamped ----------------
    logic               r_vld2;
    t_item              r_item2;
    logic signed [31:0] r_m [3][3];
    logic signed [39:0] rp [6];
    logic signed [39:0] rs [3];
    logic signed [39:0] mm [3][3];
    logic signed [66:0] tp;
    logic signed [49:0] ts;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            tp    = (r_p[k] + (67'sd1 <<< 29)) >>> 30;
            rp[k] = 40'(tp);
        end
        for (int k = 0; k < 3; k++) begin
            ts    = (r_sa[k] + 50'sd32768) >>> 16;
            rs[k] = 40'(ts);
        end
        mm[0][0] = rp[AXX] + 40'(r_rc);
        mm[1][1] = rp[AYY] + 40'(r_rc);
        mm[2][2] = rp[AZZ] + 40'(r_rc);
        mm[0][1] = rp[AXY] - rs[2];
        mm[1][0] = rp[AXY] + rs[2];
        mm[0][2] = rp[AXZ] + rs[1];
        mm[2][0] = rp[AXZ] - rs[1];
        mm[1][2] = rp[AYZ] - rs[0];
        mm[2][1] = rp[AYZ] + rs[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (en) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item2 <= r_item1;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (mm[i][j] > 40'(ONE_Q30)) begin
                        r_m[i][j] <= 32'(ONE_Q30);
                    end else if (mm[i][j] < -40'(ONE_Q30)) begin
                        r_m[i][j] <= -32'(ONE_Q30);
                    end else begin
                        r_m[i][j] <= 32'(mm[i][j]);
                    end
                end
            end
        end
    end

    // ---------------- M3: entry * target ----------------
    logic               r_vld3;
    t_item              r_item3;
    logic signed [63:0] r_pr [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (en) begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item3 <= r_item2;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[i][j] <= 64'(r_m[i][j]) * 64'($signed(r_item2.t[j]));
                end
            end
        end
    end

    // ---------------- M4: sum, round, saturate; output register ----------------
    logic               r_vld4;
    logic signed [31:0] r_res [3];
    logic               r_ok;
    logic signed [65:0] acc;
    logic signed [65:0] rnd;
    logic signed [31:0] n_res [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc = 66'(r_pr[i][0]) + 66'(r_pr[i][1]) + 66'(r_pr[i][2]);
            rnd = (acc + (66'sd1 <<< 27)) >>> 28;
            if (!r_item3.ok) begin
                n_res[i] = $signed(r_item3.t[i]);
            end else if (rnd > 66'sd2147483647) begin
                n_res[i] = 32'sh7fffffff;
            end else if (rnd < -66'sd2147483648) begin
                n_res[i] = 32'sh80000000;
            end else begin
                n_res[i] = 32'(rnd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (en) begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_ok  <= r_item3.ok;
        end
    end

    // pipeline moves unless the output word is stuck
    assign en = !r_vld4 || o_rot.ready;

    assign i_vec.ready    = en;
    assign o_rot.valid    = r_vld4;
    assign o_rot.result_x = r_res[0];
    assign o_rot.result_y = r_res[1];
    assign o_rot.result_z = r_res[2];
    assign o_rot.ok       = r_ok;

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rot.valid)
        else $error("output valid right after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rot.valid && !o_rot.ready |-> !i_vec.ready)
        else $error("input taken while output word stalled");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rot.valid |-> i_vec.ready)
        else $error("input blocked with empty output register");
`endif

endmodule

// ===== bench/aavr_rotation_checker.sv =====
// ----------------------------------------------------------------------------
// aavr_rotation_checker - rotation predictor and scoreboard
// Watches both channels, predicts each rotated word and compares in order.
// ----------------------------------------------------------------------------
module aavr_rotation_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aavr_in_if         i_vec,
    aavr_out_if        o_rot,
    output int         o_errors,
    output int         o_pending,
    output int         o_rotated,
    output int         o_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ok;
    } t_rot_word;

    t_rot_word rot_expected_q[$];

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    function automatic logic signed [31:0] sat_word(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_rot_word predict_rotation(
        logic signed [31:0] tx, logic signed [31:0] ty, logic signed [31:0] tz,
        logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az,
        logic [15:0] ang);
        t_rot_word r;
        longint t[3], a[3], m[3][3];
        longint q, z, x, y, dx, dy, c, s, oc, acc, v, sx, sy, sz;
        bit flip;
        longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
            326, 163, 81};
        t[0] = tx; t[1] = ty; t[2] = tz;
        a[0] = ax; a[1] = ay; a[2] = az;
        q = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        if (q < 263093591 || q > 273831008) begin
            r.x = tx; r.y = ty; r.z = tz; r.ok = 1'b0;
            return r;
        end
        // angle to 32-bit binary angle, folded into +-1/4 turn
        z = longint'(ang) << 16;
        flip = 0;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; flip = 1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; flip = 1;
        end
        x = 652032874; y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        oc = 64'sd1073741824 - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                v = round_sh(oc * (a[i] * a[j]), 30);
                if (i == j) v += round_sh(c, 2);
                m[i][j] = v;
            end
        sx = round_sh(s * a[0], 16);
        sy = round_sh(s * a[1], 16);
        sz = round_sh(s * a[2], 16);
        m[0][1] -= sz; m[1][0] += sz;
        m[0][2] += sy; m[2][0] -= sy;
        m[1][2] -= sx; m[2][1] += sx;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += clamp_one(m[i][j]) * t[j];
            if (i == 0) r.x = sat_word(round_sh(acc, 28));
            if (i == 1) r.y = sat_word(round_sh(acc, 28));
            if (i == 2) r.z = sat_word(round_sh(acc, 28));
        end
        r.ok = 1'b1;
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_rotated = 0;
        o_rejected = 0;
    end

    assign o_pending = rot_expected_q.size();

    always @(posedge i_clk) begin
        t_rot_word want;
        if (i_rst_n && i_vec.valid && i_vec.ready)
            rot_expected_q.push_back(predict_rotation(i_vec.target_x, i_vec.target_y,
                i_vec.target_z, i_vec.axis_x, i_vec.axis_y, i_vec.axis_z, i_vec.angle));
        if (i_rst_n && o_rot.valid && o_rot.ready) begin
            if (rot_expected_q.size() == 0) begin
                o_errors <= o_errors + 1;
                if (o_errors < 10)
                    $display("%t: unexpected word x=%h y=%h z=%h ok=%b", $realtime,
                        o_rot.result_x, o_rot.result_y, o_rot.result_z, o_rot.ok);
            end else begin
                want = rot_expected_q.pop_front();
                if (want.ok) o_rotated <= o_rotated + 1;
                else o_rejected <= o_rejected + 1;
                if (want.x !== o_rot.result_x || want.y !== o_rot.result_y ||
                    want.z !== o_rot.result_z || want.ok !== o_rot.ok) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("%t: mismatch exp x=%h y=%h z=%h ok=%b got x=%h y=%h z=%h ok=%b",
                            $realtime, want.x, want.y, want.z, want.ok, o_rot.result_x,
                            o_rot.result_y, o_rot.result_z, o_rot.ok);
                end
            end
        end
    end

endmodule

// ===== bench/axis_angle_vector_rotation_top_test.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_top_test - rotator regression
// Directed corner words then random axis/angle/target words with random gaps
// and output stalls; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import aavr_pkg::*;

    localparam int STAGES = 16;
    localparam int N_RANDOM = 1200;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, n_rotated, n_rejected;
    bit   stim_done;
    bit   long_hold_req;

    aavr_in_if  vec_ch ();
    aavr_out_if rot_ch ();

    axis_angle_vector_rotation_top #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vec(vec_ch), .o_rot(rot_ch)
    );

    aavr_rotation_checker #(.CORDIC_STAGES(STAGES)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vec(vec_ch), .o_rot(rot_ch),
        .o_errors(errors), .o_pending(pending),
        .o_rotated(n_rotated), .o_rejected(n_rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one word and hold it until the block takes it.
    task automatic send_word(logic signed [31:0] tx, logic signed [31:0] ty,
                             logic signed [31:0] tz, logic signed [15:0] ax,
                             logic signed [15:0] ay, logic signed [15:0] az,
                             logic [15:0] ang, bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            vec_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vec_ch.valid    <= 1'b1;
        vec_ch.target_x <= tx;
        vec_ch.target_y <= ty;
        vec_ch.target_z <= tz;
        vec_ch.axis_x   <= ax;
        vec_ch.axis_y   <= ay;
        vec_ch.axis_z   <= az;
        vec_ch.angle    <= ang;
        do @(posedge i_clk); while (!vec_ch.ready);
    endtask

    // Random unit axis in Q2.14, nudged within (or just past) tolerance.
    task automatic make_axis(output logic signed [15:0] ax, output logic signed [15:0] ay,
                             output logic signed [15:0] az);
        real ux, uy, uz, n, k;
        ux = real'($urandom_range(0, 2000)) - 1000.0;
        uy = real'($urandom_range(0, 2000)) - 1000.0;
        uz = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(ux*ux + uy*uy + uz*uz);
        if (n < 1.0) begin
            ux = 1.0; n = 1.0;
        end
        k = 16384.0 * (0.985 + real'($urandom_range(0, 300)) / 10000.0) / n;
        ax = 16'($rtoi(ux * k));
        ay = 16'($rtoi(uy * k));
        az = 16'($rtoi(uz * k));
    endtask

    function automatic logic [31:0] rand_target();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 65535 * 4)) - 32'sd131070;
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom()) >>> $urandom_range(0, 24);
        endcase
    endfunction

    // Output side: random stalls, plus one long hold on request.
    initial begin
        int gap;
        rot_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                rot_ch.ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                long_hold_req = 0;
            end
            gap = stim_done ? 0 : pick_gap();
            if (gap > 0) begin
                rot_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rot_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic signed [15:0] ax, ay, az;
        int wait_cnt;
        vec_ch.valid <= 1'b0;
        vec_ch.target_x <= '0; vec_ch.target_y <= '0; vec_ch.target_z <= '0;
        vec_ch.axis_x <= '0; vec_ch.axis_y <= '0; vec_ch.axis_z <= '0;
        vec_ch.angle <= '0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: exact unit axes, extremes of the angle and targets.
        send_word(32'sh00010000, 0, 0, 16'sd0, 16'sd0, 16'sd16384, 16'h4000, 1);
        send_word(32'sh00010000, 32'sh00020000, 0, 16'sd16384, 0, 0, 16'h8000, 1);
        send_word(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 16'sd16384, 0,
                  16'h0000, 0);
        send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 16'sd9459, 16'sd9459,
                  16'sd9459, 16'hffff, 0);
        send_word(32'sh80000000, 32'sh80000000, 32'sh80000000, -16'sd9459, 16'sd9459,
                  -16'sd9459, 16'h2000, 0);
        send_word(32'sh12345678, -32'sd5, 32'sd77, 0, 0, -16'sd16384, 16'hc000, 0);
        send_word(32'sh12345678, 1, 2, 0, 0, 0, 16'h1234, 0);               // zero axis
        send_word(32'sh0000ffff, 3, 4, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h4000, 0);
        send_word(5, 6, 7, 16'sh8000, 16'sh8000, 16'sh8000, 16'hbfff, 0);
        // axis length right at the tolerance bounds
        send_word(32'sh00030000, 0, 0, 16'sd16220, 0, 0, 16'h1000, 0);
        send_word(32'sh00030000, 0, 0, 16'sd16219, 0, 0, 16'h1000, 0);
        send_word(32'sh00030000, 0, 0, 16'sd16547, 0, 0, 16'h1000, 0);
        send_word(32'sh00030000, 0, 0, 16'sd16548, 0, 0, 16'h1000, 0);
        send_word(32'sh00030000, 0, 0, -16'sd16548, 0, 0, 16'h4001, 0);
        send_word(32'sh00010000, 32'sh00010000, 32'sh00010000, 0, 16'sd16384, 0,
                  16'h3fff, 0);
        send_word(32'sh00010000, 32'sh00010000, 32'sh00010000, 0, 16'sd16384, 0,
                  16'h7fff, 0);
        send_word(32'sh00010000, 32'sh00010000, 32'sh00010000, 0, 16'sd16384, 0,
                  16'h8001, 0);

        // Sender pauses until every expected word has come back.
        vec_ch.valid <= 1'b0;
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) long_hold_req = 1;
            if ($urandom_range(0, 9) < 8) make_axis(ax, ay, az);
            else begin
                ax = 16'($urandom()); ay = 16'($urandom()); az = 16'($urandom());
            end
            send_word(rand_target(), rand_target(), rand_target(), ax, ay, az,
                      16'($urandom()), n >= 400 && n < 500);
        end
        vec_ch.valid <= 1'b0;
        stim_done = 1;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (STAGES + 20) @(posedge i_clk);
        $display("Covered %0d rotated and %0d rejected-axis words, with stalls on both sides.",
                 n_rotated, n_rejected);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
